// ===== rtl/steered_car_dual_pi_drive_macros.svh =====
// Assertion macros shared by the drive controller RTL.
`ifndef STEERED_CAR_DUAL_PI_DRIVE_MACROS_SVH
`define STEERED_CAR_DUAL_PI_DRIVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCPD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drive controller check failed");

// Next-cycle implication, disabled during reset.
`define SCPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drive controller check failed");

`endif

// ===== rtl/scpd_pkg.sv =====
// Types, widths and constants of the dual PI drive controller.
`default_nettype none

package scpd_pkg;

    localparam int ACCUM_BITS       = 32;
    localparam int FACTOR_FRAC_BITS = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CMD_W       = 4;
    localparam int ENC_W       = 16;
    localparam int ENC_EXT_W   = ENC_W + 1;
    localparam int SPD_W       = 12;
    localparam int MAG_W       = SPD_W - 1;
    localparam int TGT_MAG_W   = 12;
    localparam int ERR_W       = 18;
    localparam int GAIN_W      = 10;
    localparam int LIMIT_W     = 13;
    localparam int DRV_W       = LIMIT_W + 1;
    localparam int PWM_W       = 16;
    localparam int PWM_EXT_W   = PWM_W + 2;
    localparam int SERVO_W     = 12;
    localparam int SERVO_EXT_W = SERVO_W + 2;

    localparam int FAC_W   = FACTOR_FRAC_BITS + 1;
    localparam int MUL_A_W = ERR_W;
    localparam int MUL_B_W = (FAC_W > GAIN_W) ? FAC_W : GAIN_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int SUM_W   = ((ACCUM_BITS > PROD_W) ? ACCUM_BITS : PROD_W) + 2;

    localparam longint D30_Q30  = 64'sd334630867;
    localparam longint D45_Q30  = 64'sd579597663;
    localparam longint FAC_HALF = longint'(1) << (29 - FACTOR_FRAC_BITS);
    localparam longint FAC_ONE  = longint'(1) << FACTOR_FRAC_BITS;
    localparam longint FAC_D30  = (D30_Q30 + FAC_HALF) >>> (30 - FACTOR_FRAC_BITS);
    localparam longint FAC_D45  = (D45_Q30 + FAC_HALF) >>> (30 - FACTOR_FRAC_BITS);

    localparam logic [FAC_W-1:0] FAC_STRAIGHT = FAC_W'(FAC_ONE);
    localparam logic [FAC_W-1:0] FAC_P30      = FAC_W'(FAC_ONE + FAC_D30);
    localparam logic [FAC_W-1:0] FAC_M30      = FAC_W'(FAC_ONE - FAC_D30);
    localparam logic [FAC_W-1:0] FAC_P45      = FAC_W'(FAC_ONE + FAC_D45);
    localparam logic [FAC_W-1:0] FAC_M45      = FAC_W'(FAC_ONE - FAC_D45);

    localparam logic signed [SUM_W-1:0] ACC_HI =
        SUM_W'((longint'(1) << (ACCUM_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - SUM_W'(1);

    localparam logic signed [SERVO_EXT_W-1:0] SERVO_OFS_30   = 14'sd419;
    localparam logic signed [SERVO_EXT_W-1:0] SERVO_OFS_30_1 = 14'sd420;
    localparam logic signed [SERVO_EXT_W-1:0] SERVO_SPAN     = 14'sd500;
    localparam logic signed [SERVO_EXT_W-1:0] SERVO_MAX      = 14'sd4095;

    localparam logic [SERVO_W-1:0] CENTER_RST = 12'd1500;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 13'd6900;
    localparam logic [PWM_W-1:0]   PERIOD_RST = 16'd7200;

    localparam logic [2:0] OBS_CLEAR             = 3'b111;
    localparam logic [2:0] OBS_LEFT_BLOCKED      = 3'b011;
    localparam logic [2:0] OBS_RIGHT_BLOCKED     = 3'b110;
    localparam logic [2:0] OBS_ONLY_RIGHT_CLEAR  = 3'b001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSTACLE_MODE = 3'd0,
        CFG_CRUISE_SPEED  = 3'd1,
        CFG_GAIN_P        = 3'd2,
        CFG_GAIN_I        = 3'd3,
        CFG_SERVO_CENTER  = 3'd4,
        CFG_DRIVE_LIMIT   = 3'd5,
        CFG_PWM_PERIOD    = 3'd6
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_FWD        = 4'd0,
        CMD_STOP       = 4'd1,
        CMD_BACK       = 4'd2,
        CMD_FWD_RIGHT  = 4'd3,
        CMD_FWD_LEFT   = 4'd4,
        CMD_BACK_RIGHT = 4'd5,
        CMD_BACK_LEFT  = 4'd6,
        CMD_BIG_RIGHT  = 4'd7,
        CMD_BIG_LEFT   = 4'd8,
        CMD_NONE       = 4'd9
    } t_cmd;

    typedef enum logic [2:0] {
        STEER_STRAIGHT = 3'd0,
        STEER_R30      = 3'd1,
        STEER_L30      = 3'd2,
        STEER_R45      = 3'd3,
        STEER_L45      = 3'd4
    } t_steer;

    typedef struct packed {
        logic                 obstacle_mode;
        logic [MAG_W-1:0]     cruise_speed;
        logic [GAIN_W-1:0]    gain_p;
        logic [GAIN_W-1:0]    gain_i;
        logic [SERVO_W-1:0]   servo_center;
        logic [LIMIT_W-1:0]   drive_limit;
        logic [PWM_W-1:0]     pwm_period;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [2:0]              obstacle;
        logic signed [ENC_W-1:0] enc_left;
        logic signed [ENC_W-1:0] enc_right;
    } t_item;

    typedef struct packed {
        logic [PWM_W-1:0]   pwm_a_forward;
        logic [PWM_W-1:0]   pwm_a_reverse;
        logic [PWM_W-1:0]   pwm_b_forward;
        logic [PWM_W-1:0]   pwm_b_reverse;
        logic [SERVO_W-1:0] servo_pulse;
    } t_result;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0]        b;
    } t_mul_req;

endpackage

`default_nettype wire

// ===== rtl/scpd_if.sv =====
// Channel interfaces: tick input, result output and configuration writes.
`default_nettype none

interface scpd_item_if;
    import scpd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic                    obstacle_left;
    logic                    obstacle_center;
    logic                    obstacle_right;
    logic signed [ENC_W-1:0] encoder_left_count;
    logic signed [ENC_W-1:0] encoder_right_count;

    modport source (
        output valid, command, obstacle_left, obstacle_center, obstacle_right,
        output encoder_left_count, encoder_right_count,
        input  ready
    );
    modport sink (
        input  valid, command, obstacle_left, obstacle_center, obstacle_right,
        input  encoder_left_count, encoder_right_count,
        output ready
    );
endinterface

interface scpd_result_if;
    import scpd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PWM_W-1:0]   pwm_a_forward;
    logic [PWM_W-1:0]   pwm_a_reverse;
    logic [PWM_W-1:0]   pwm_b_forward;
    logic [PWM_W-1:0]   pwm_b_reverse;
    logic [SERVO_W-1:0] servo_pulse;

    modport source (
        output valid, pwm_a_forward, pwm_a_reverse, pwm_b_forward, pwm_b_reverse,
        output servo_pulse,
        input  ready
    );
    modport sink (
        input  valid, pwm_a_forward, pwm_a_reverse, pwm_b_forward, pwm_b_reverse,
        input  servo_pulse,
        output ready
    );
endinterface

interface scpd_cfg_if;
    import scpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/steered_car_dual_pi_drive.sv =====
// Top level of the two-wheel PI drive controller with steering servo output.
//
//  channel   | dir | beat payload
//  ----------+-----+-----------------------------------------------------------
//  i_item    | in  | command, three obstacle bits, left and right encoder counts
//  o_result  | out | two H-bridge compare pairs and the servo pulse
//  i_cfg     | in  | register index and write data
//
// Each tick is accepted, then runs eight sequencer steps that push two
// wheel targets and four PI products through the single shared multiplier.
// The result lands in the output register on the last step; ready returns the
// next cycle. Reset is synchronous, loads the register defaults and clears
// speed, steering, both accumulators and previous errors.
// A held result stalls only the last step.
`default_nettype none

module steered_car_dual_pi_drive (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scpd_item_if.sink      i_item,
    scpd_result_if.source  o_result,
    scpd_cfg_if.sink       i_cfg
);
    import scpd_pkg::*;

`include "steered_car_dual_pi_drive_macros.svh"

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_busy;
    logic    w_done;
    logic    w_start;
    logic    w_out_free;

    scpd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_item.command   = i_item.command;
    assign w_item.obstacle  = {i_item.obstacle_left, i_item.obstacle_center,
                               i_item.obstacle_right};
    assign w_item.enc_left  = i_item.encoder_left_count;
    assign w_item.enc_right = i_item.encoder_right_count;

    assign i_item.ready = !w_busy;
    assign w_start      = i_item.valid & !w_busy;
    assign w_out_free   = !r_out_valid | o_result.ready;

    scpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_item     (w_item),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.pwm_a_forward = r_out.pwm_a_forward;
    assign o_result.pwm_a_reverse = r_out.pwm_a_reverse;
    assign o_result.pwm_b_forward = r_out.pwm_b_forward;
    assign o_result.pwm_b_reverse = r_out.pwm_b_reverse;
    assign o_result.servo_pulse   = r_out.servo_pulse;

    `SCPD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_item.valid && i_item.ready, !i_item.ready)
    `SCPD_ASSERT_SAME(a_done_into_free_slot, i_clk, i_rst_n, w_done, !r_out_valid || o_result.ready)
    `SCPD_ASSERT_NEXT(a_result_after_done, i_clk, i_rst_n, w_done, r_out_valid && i_item.ready)

endmodule

`default_nettype wire

// ===== rtl/scpd_cfg_regs.sv =====
// Configuration register file written through the configuration channel.
`default_nettype none

module scpd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    scpd_cfg_if.sink       i_cfg,
    output scpd_pkg::t_cfg o_cfg
);
    import scpd_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid & i_cfg.ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_mode <= 1'b0;
            r_cfg.cruise_speed  <= '0;
            r_cfg.gain_p        <= '0;
            r_cfg.gain_i        <= '0;
            r_cfg.servo_center  <= CENTER_RST;
            r_cfg.drive_limit   <= LIMIT_RST;
            r_cfg.pwm_period    <= PERIOD_RST;
        end else if (w_wr) begin
            unique case (i_cfg.index)
                CFG_OBSTACLE_MODE: r_cfg.obstacle_mode <= i_cfg.data[0];
                CFG_CRUISE_SPEED:  r_cfg.cruise_speed  <= i_cfg.data[MAG_W-1:0];
                CFG_GAIN_P:        r_cfg.gain_p        <= i_cfg.data[GAIN_W-1:0];
                CFG_GAIN_I:        r_cfg.gain_i        <= i_cfg.data[GAIN_W-1:0];
                CFG_SERVO_CENTER:  r_cfg.servo_center  <= i_cfg.data[SERVO_W-1:0];
                CFG_DRIVE_LIMIT:   r_cfg.drive_limit   <= i_cfg.data[LIMIT_W-1:0];
                CFG_PWM_PERIOD:    r_cfg.pwm_period    <= i_cfg.data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scpd_mul.sv =====
// Shared signed-by-unsigned multiplier with registered product.
`default_nettype none

module scpd_mul (
    input  logic                               i_clk,
    input  scpd_pkg::t_mul_req                 i_req,
    output logic signed [scpd_pkg::PROD_W-1:0] o_prod
);
    import scpd_pkg::*;

    logic signed [MUL_B_W:0]   w_b;
    logic signed [PROD_W-1:0]  w_a_ext;
    logic signed [PROD_W-1:0]  w_b_ext;
    logic signed [PROD_W-1:0]  r_prod;

    assign w_b     = $signed({1'b0, i_req.b});
    assign w_a_ext = PROD_W'(i_req.a);
    assign w_b_ext = PROD_W'(w_b);
    assign o_prod  = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= w_a_ext * w_b_ext;
    end

endmodule

`default_nettype wire

// ===== rtl/scpd_core.sv =====
// Tick sequencer: command decode, wheel targets and both PI updates on one multiplier.
`default_nettype none

module scpd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  scpd_pkg::t_item   i_item,
    input  scpd_pkg::t_cfg    i_cfg,
    input  logic              i_out_free,
    output logic              o_busy,
    output logic              o_done,
    output scpd_pkg::t_result o_result
);
    import scpd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TL, S_TR, S_PL, S_IL, S_PR, S_IR, S_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic [PWM_W-1:0] fwd;
        logic [PWM_W-1:0] rev;
    } t_bridge;

    t_state                        r_state, n_state;
    logic signed [SPD_W-1:0]       r_held, n_held;
    t_steer                        r_steer, n_steer;
    logic signed [ACCUM_BITS-1:0]  r_acc_l, n_acc_l, r_acc_r, n_acc_r;
    logic signed [ERR_W-1:0]       r_prev_l, n_prev_l, r_prev_r, n_prev_r;
    logic signed [ERR_W-1:0]       r_err_l, n_err_l, r_err_r, n_err_r;
    logic signed [ENC_EXT_W-1:0]   r_enc_l, n_enc_l, r_enc_r, n_enc_r;
    logic signed [SUM_W-1:0]       r_sum, n_sum;

    t_mul_req                      w_req;
    logic signed [PROD_W-1:0]      w_prod;

    logic [CMD_W-1:0]              w_cmd;
    logic signed [SPD_W-1:0]       w_cs_pos, w_cs_neg;
    logic signed [SPD_W-1:0]       w_dec_held;
    t_steer                        w_dec_steer;

    logic [FAC_W-1:0]              w_fac_l, w_fac_r;
    logic signed [SPD_W-1:0]       w_abs;
    logic [MAG_W-1:0]              w_mag;
    logic [TGT_MAG_W-1:0]          w_tgt_mag;
    logic signed [TGT_MAG_W:0]     w_tgt_pos, w_tgt;
    logic signed [ENC_EXT_W-1:0]   w_enc_sel;
    logic signed [ERR_W-1:0]       w_err;
    logic signed [ACCUM_BITS-1:0]  w_acc_sel;
    logic signed [SUM_W-1:0]       w_sum_start, w_sum_end;
    logic signed [ACCUM_BITS-1:0]  w_sat;

    logic signed [SERVO_EXT_W-1:0] w_center, w_servo;
    t_bridge                       w_br_a, w_br_b;

    function automatic logic signed [DRV_W-1:0] clamp_drive(
        input logic signed [ACCUM_BITS-1:0] acc,
        input logic [LIMIT_W-1:0]           lim
    );
        logic signed [ACCUM_BITS-1:0] hi;
        logic signed [ACCUM_BITS-1:0] lo;
        logic signed [DRV_W-1:0]      m;
        hi = $signed(ACCUM_BITS'(lim));
        lo = -hi;
        if (acc > hi) begin
            m = DRV_W'(hi);
        end else if (acc < lo) begin
            m = DRV_W'(lo);
        end else begin
            m = DRV_W'(acc);
        end
        return m;
    endfunction

    function automatic t_bridge split_bridge(
        input logic signed [DRV_W-1:0] m,
        input logic [PWM_W-1:0]        p
    );
        t_bridge                     b;
        logic signed [PWM_EXT_W-1:0] pe;
        logic signed [PWM_EXT_W-1:0] me;
        logic signed [PWM_EXT_W-1:0] f;
        logic signed [PWM_EXT_W-1:0] r;
        pe = $signed(PWM_EXT_W'(p));
        me = PWM_EXT_W'(m);
        if (me[PWM_EXT_W-1]) begin
            f = pe;
            r = pe + me;
        end else begin
            f = pe - me;
            r = pe;
        end
        b.fwd = f[PWM_EXT_W-1] ? '0 : f[PWM_W-1:0];
        b.rev = r[PWM_EXT_W-1] ? '0 : r[PWM_W-1:0];
        return b;
    endfunction

    scpd_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // command decode for the accepted beat
    assign w_cs_pos = $signed({1'b0, i_cfg.cruise_speed});
    assign w_cs_neg = -w_cs_pos;

    always_comb begin
        w_cmd       = i_item.command;
        w_dec_held  = r_held;
        w_dec_steer = r_steer;
        if (i_cfg.obstacle_mode) begin
            unique case (i_item.obstacle)
                OBS_CLEAR:            w_cmd = CMD_FWD;
                OBS_LEFT_BLOCKED:     w_cmd = CMD_FWD_RIGHT;
                OBS_RIGHT_BLOCKED:    w_cmd = CMD_FWD_LEFT;
                OBS_ONLY_RIGHT_CLEAR: begin
                    w_dec_held = w_cs_neg;
                    w_cmd      = CMD_BIG_RIGHT;
                end
                default: begin
                    w_dec_held = w_cs_neg;
                    w_cmd      = CMD_BIG_LEFT;
                end
            endcase
        end
        unique case (w_cmd)
            CMD_FWD: begin
                w_dec_held  = w_cs_pos;
                w_dec_steer = STEER_STRAIGHT;
            end
            CMD_STOP: begin
                w_dec_held  = '0;
                w_dec_steer = STEER_STRAIGHT;
            end
            CMD_BACK: begin
                w_dec_held  = w_cs_neg;
                w_dec_steer = STEER_STRAIGHT;
            end
            CMD_FWD_RIGHT: begin
                w_dec_held  = w_cs_pos;
                w_dec_steer = STEER_R30;
            end
            CMD_FWD_LEFT: begin
                w_dec_held  = w_cs_pos;
                w_dec_steer = STEER_L30;
            end
            CMD_BACK_RIGHT: begin
                w_dec_held  = w_cs_neg;
                w_dec_steer = STEER_R30;
            end
            CMD_BACK_LEFT: begin
                w_dec_held  = w_cs_neg;
                w_dec_steer = STEER_L30;
            end
            CMD_BIG_RIGHT: w_dec_steer = STEER_R45;
            CMD_BIG_LEFT:  w_dec_steer = STEER_L45;
            default: ;
        endcase
    end

    always_comb begin
        case (r_steer)
            STEER_R30: begin
                w_fac_l = FAC_P30;
                w_fac_r = FAC_M30;
            end
            STEER_L30: begin
                w_fac_l = FAC_M30;
                w_fac_r = FAC_P30;
            end
            STEER_R45: begin
                w_fac_l = FAC_P45;
                w_fac_r = FAC_M45;
            end
            STEER_L45: begin
                w_fac_l = FAC_M45;
                w_fac_r = FAC_P45;
            end
            default: begin
                w_fac_l = FAC_STRAIGHT;
                w_fac_r = FAC_STRAIGHT;
            end
        endcase
    end

    // shared datapath around the product register
    assign w_abs       = r_held[SPD_W-1] ? -r_held : r_held;
    assign w_mag       = w_abs[MAG_W-1:0];
    assign w_tgt_mag   = w_prod[FACTOR_FRAC_BITS +: TGT_MAG_W];
    assign w_tgt_pos   = $signed({1'b0, w_tgt_mag});
    assign w_tgt       = r_held[SPD_W-1] ? -w_tgt_pos : w_tgt_pos;
    assign w_enc_sel   = (r_state == S_TR) ? r_enc_l : r_enc_r;
    assign w_err       = ERR_W'(w_tgt) - ERR_W'(w_enc_sel);
    assign w_acc_sel   = (r_state == S_IL) ? r_acc_l : r_acc_r;
    assign w_sum_start = SUM_W'(w_acc_sel) + SUM_W'(w_prod);
    assign w_sum_end   = r_sum + SUM_W'(w_prod);

    always_comb begin
        if (w_sum_end > ACC_HI) begin
            w_sat = ACCUM_BITS'(ACC_HI);
        end else if (w_sum_end < ACC_LO) begin
            w_sat = ACCUM_BITS'(ACC_LO);
        end else begin
            w_sat = ACCUM_BITS'(w_sum_end);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_steer  = r_steer;
        n_acc_l  = r_acc_l;
        n_acc_r  = r_acc_r;
        n_prev_l = r_prev_l;
        n_prev_r = r_prev_r;
        n_err_l  = r_err_l;
        n_err_r  = r_err_r;
        n_enc_l  = r_enc_l;
        n_enc_r  = r_enc_r;
        n_sum    = r_sum;
        w_req    = '0;
        o_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_held  = w_dec_held;
                    n_steer = w_dec_steer;
                    n_enc_l = ENC_EXT_W'(i_item.enc_left);
                    n_enc_r = -ENC_EXT_W'(i_item.enc_right);
                    n_state = S_TL;
                end
            end
            S_TL: begin
                w_req.a = MUL_A_W'(w_mag);
                w_req.b = MUL_B_W'(w_fac_l);
                n_state = S_TR;
            end
            S_TR: begin
                n_err_l = w_err;
                w_req.a = MUL_A_W'(w_mag);
                w_req.b = MUL_B_W'(w_fac_r);
                n_state = S_PL;
            end
            S_PL: begin
                n_err_r = w_err;
                w_req.a = MUL_A_W'(r_err_l - r_prev_l);
                w_req.b = MUL_B_W'(i_cfg.gain_p);
                n_state = S_IL;
            end
            S_IL: begin
                n_sum   = w_sum_start;
                w_req.a = r_err_l;
                w_req.b = MUL_B_W'(i_cfg.gain_i);
                n_state = S_PR;
            end
            S_PR: begin
                n_acc_l  = w_sat;
                n_prev_l = r_err_l;
                w_req.a  = MUL_A_W'(r_err_r - r_prev_r);
                w_req.b  = MUL_B_W'(i_cfg.gain_p);
                n_state  = S_IR;
            end
            S_IR: begin
                n_sum   = w_sum_start;
                w_req.a = r_err_r;
                w_req.b = MUL_B_W'(i_cfg.gain_i);
                n_state = S_FIN;
            end
            S_FIN: begin
                n_acc_r  = w_sat;
                n_prev_r = r_err_r;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_held   <= '0;
            r_steer  <= STEER_STRAIGHT;
            r_acc_l  <= '0;
            r_acc_r  <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
        end else begin
            r_state  <= n_state;
            r_held   <= n_held;
            r_steer  <= n_steer;
            r_acc_l  <= n_acc_l;
            r_acc_r  <= n_acc_r;
            r_prev_l <= n_prev_l;
            r_prev_r <= n_prev_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err_l <= n_err_l;
        r_err_r <= n_err_r;
        r_enc_l <= n_enc_l;
        r_enc_r <= n_enc_r;
        r_sum   <= n_sum;
    end

    // result forming from the updated accumulators
    assign w_center = $signed(SERVO_EXT_W'(i_cfg.servo_center));

    always_comb begin
        case (r_steer)
            STEER_R30: w_servo = w_center + SERVO_OFS_30;
            STEER_L30: w_servo = (w_center > SERVO_OFS_30) ? w_center - SERVO_OFS_30_1
                                                            : w_center - SERVO_OFS_30;
            STEER_R45: w_servo = w_center + SERVO_SPAN;
            STEER_L45: w_servo = w_center - SERVO_SPAN;
            default:   w_servo = w_center;
        endcase
    end

    assign w_br_a = split_bridge(clamp_drive(r_acc_l, i_cfg.drive_limit), i_cfg.pwm_period);
    assign w_br_b = split_bridge(clamp_drive(r_acc_r, i_cfg.drive_limit), i_cfg.pwm_period);

    always_comb begin
        o_result.pwm_a_forward = w_br_a.fwd;
        o_result.pwm_a_reverse = w_br_a.rev;
        o_result.pwm_b_forward = w_br_b.fwd;
        o_result.pwm_b_reverse = w_br_b.rev;
        if (w_servo[SERVO_EXT_W-1]) begin
            o_result.servo_pulse = '0;
        end else if (w_servo > SERVO_MAX) begin
            o_result.servo_pulse = SERVO_MAX[SERVO_W-1:0];
        end else begin
            o_result.servo_pulse = w_servo[SERVO_W-1:0];
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dual PI drive controller: directed ticks, then random phases.
module testbench;
    import scpd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int HOLD_CYCLES     = 90;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int PRESSURE_AT     = 40;
    localparam int PIN_FLIP        = 78;
    localparam int DIR_SPLIT       = 12;
    localparam int DIR_ROWS        = 20;

    localparam longint TAN30_Q30 = 64'sd334630867;
    localparam longint TAN45_Q30 = 64'sd579597663;
    localparam longint UNITY_Q   = longint'(1) << FACTOR_FRAC_BITS;
    localparam longint HALF_LSB  = longint'(1) << (29 - FACTOR_FRAC_BITS);
    localparam longint DELTA30_Q = (TAN30_Q30 + HALF_LSB) >>> (30 - FACTOR_FRAC_BITS);
    localparam longint DELTA45_Q = (TAN45_Q30 + HALF_LSB) >>> (30 - FACTOR_FRAC_BITS);
    localparam longint ACC_MAX   = (longint'(1) << (ACCUM_BITS - 1)) - 1;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam longint SERVO_TOP = 4095;
    localparam longint TURN30    = 419;
    localparam longint TURN45    = 500;

    localparam logic [CMD_W-1:0] CMD_UNUSED_MAX = 4'hF;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_CYCLE, SINK_SPARSE} t_sink_mode;
    typedef enum logic [1:0] {FEED_TRACK, FEED_PINNED, FEED_NOISE} t_feed_mode;
    typedef enum logic [1:0] {PRESS_NONE, PRESS_HOLD, PRESS_DRAIN} t_pressure;

    typedef struct packed {
        t_item   tick;
        logic    typed;
        t_result want;
    } t_row;

    localparam t_result NO_WANT = '0;
    localparam t_result RST_STRAIGHT =
        '{PERIOD_RST, PERIOD_RST, PERIOD_RST, PERIOD_RST, 12'd1500};
    localparam t_result RST_R30 = '{PERIOD_RST, PERIOD_RST, PERIOD_RST, PERIOD_RST, 12'd1919};
    localparam t_result RST_L30 = '{PERIOD_RST, PERIOD_RST, PERIOD_RST, PERIOD_RST, 12'd1080};
    localparam t_result RST_R45 = '{PERIOD_RST, PERIOD_RST, PERIOD_RST, PERIOD_RST, 12'd2000};
    localparam t_result RST_L45 = '{PERIOD_RST, PERIOD_RST, PERIOD_RST, PERIOD_RST, 12'd1000};

    localparam t_cfg SET_FULL_TILT =
        '{1'b1, 11'd2047, 10'd1023, 10'd1023, 12'd3000, 13'd7200, 16'd7200};

    // gains and speed are zero out of reset, so the first block is servo-only
    t_row dir_rows [DIR_ROWS] = '{
        '{'{CMD_FWD,        3'b111, 16'sh7FFF, 16'sh8000}, 1'b1, RST_STRAIGHT},
        '{'{CMD_STOP,       3'b000, 16'sh8000, 16'sh7FFF}, 1'b1, RST_STRAIGHT},
        '{'{CMD_BACK,       3'b101, 16'sh0000, 16'shFFFF}, 1'b1, RST_STRAIGHT},
        '{'{CMD_FWD_RIGHT,  3'b010, 16'sh0001, 16'sh0000}, 1'b1, RST_R30},
        '{'{CMD_FWD_LEFT,   3'b011, 16'shFFFF, 16'sh0001}, 1'b1, RST_L30},
        '{'{CMD_BACK_RIGHT, 3'b100, 16'sh5555, 16'shAAAA}, 1'b1, RST_R30},
        '{'{CMD_BACK_LEFT,  3'b110, 16'shAAAA, 16'sh5555}, 1'b1, RST_L30},
        '{'{CMD_BIG_RIGHT,  3'b001, 16'sh0100, 16'shFF00}, 1'b1, RST_R45},
        '{'{CMD_NONE,       3'b111, 16'sh0000, 16'sh0000}, 1'b1, RST_R45},
        '{'{CMD_BIG_LEFT,   3'b000, 16'sh7FFF, 16'sh7FFF}, 1'b1, RST_L45},
        '{'{CMD_UNUSED_MAX, 3'b111, 16'sh8000, 16'sh8000}, 1'b1, RST_L45},
        '{'{CMD_STOP,       3'b010, 16'sh0000, 16'sh0000}, 1'b1, RST_STRAIGHT},
        '{'{CMD_STOP,       3'b111, 16'sh0000, 16'sh0000}, 1'b0, NO_WANT},
        '{'{CMD_BACK,       3'b011, 16'sh7FFF, 16'sh8000}, 1'b0, NO_WANT},
        '{'{CMD_NONE,       3'b110, 16'sh8000, 16'sh7FFF}, 1'b0, NO_WANT},
        '{'{CMD_FWD,        3'b001, 16'sh1234, 16'shEDCC}, 1'b0, NO_WANT},
        '{'{CMD_BIG_RIGHT,  3'b100, 16'sh0000, 16'sh0000}, 1'b0, NO_WANT},
        '{'{CMD_FWD,        3'b000, 16'sh8000, 16'sh8000}, 1'b0, NO_WANT},
        '{'{CMD_UNUSED_MAX, 3'b010, 16'sh7FFF, 16'sh7FFF}, 1'b0, NO_WANT},
        '{'{CMD_FWD_LEFT,   3'b101, 16'sh0400, 16'shFC00}, 1'b0, NO_WANT}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    scpd_item_if   tick_if ();
    scpd_result_if drive_if ();
    scpd_cfg_if    cfg_if ();

    steered_car_dual_pi_drive dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (tick_if),
        .o_result (drive_if),
        .i_cfg    (cfg_if)
    );

    t_cfg                          drive_cfg;
    logic signed [SPD_W-1:0]       held_speed;
    t_steer                        steer;
    logic signed [ACCUM_BITS-1:0]  accum_l, accum_r;
    logic signed [ERR_W-1:0]       prev_err_l, prev_err_r;

    t_result    pending_drive [$];
    t_sink_mode sink_mode = SINK_OPEN;
    int         hold_reqs = 0;
    int         mismatches = 0;
    int         results_seen = 0;
    int         ticks_sent = 0;
    int         reg_writes = 0;
    int         cycle_cnt = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint wheel_target(longint spd, longint fac);
        longint mag;
        longint t;
        mag = (spd < 0) ? -spd : spd;
        t = (mag * fac) >>> FACTOR_FRAC_BITS;
        return (spd < 0) ? -t : t;
    endfunction

    function automatic longint pi_next(longint acc, longint prev, longint err);
        longint v;
        v = acc + longint'(drive_cfg.gain_p) * (err - prev) + longint'(drive_cfg.gain_i) * err;
        if (v > ACC_MAX) v = ACC_MAX;
        if (v < ACC_MIN) v = ACC_MIN;
        return v;
    endfunction

    function automatic logic [2*PWM_W-1:0] bridge_split(longint m);
        longint p;
        longint f;
        longint r;
        p = longint'(drive_cfg.pwm_period);
        if (m < 0) begin
            f = p;
            r = p + m;
        end else begin
            r = p;
            f = p - m;
        end
        if (f < 0) f = 0;
        if (r < 0) r = 0;
        return {PWM_W'(f), PWM_W'(r)};
    endfunction

    // one control tick: steering and speed update, two PI loops, bridge split
    function automatic t_result drive_step(t_item t);
        logic [CMD_W-1:0]   cmd;
        longint             cs, c, sv, fa, fb, hs, err_l, err_r, ma, mb, lim;
        logic [2*PWM_W-1:0] pair;
        t_result            r;
        cmd = t.command;
        cs = longint'(drive_cfg.cruise_speed);
        if (drive_cfg.obstacle_mode) begin
            case (t.obstacle)
                OBS_CLEAR:         cmd = CMD_FWD;
                OBS_LEFT_BLOCKED:  cmd = CMD_FWD_RIGHT;
                OBS_RIGHT_BLOCKED: cmd = CMD_FWD_LEFT;
                OBS_ONLY_RIGHT_CLEAR: begin
                    held_speed = SPD_W'(-cs);
                    cmd = CMD_BIG_RIGHT;
                end
                default: begin
                    held_speed = SPD_W'(-cs);
                    cmd = CMD_BIG_LEFT;
                end
            endcase
        end
        case (cmd)
            CMD_FWD: begin
                held_speed = SPD_W'(cs);
                steer = STEER_STRAIGHT;
            end
            CMD_STOP: begin
                held_speed = '0;
                steer = STEER_STRAIGHT;
            end
            CMD_BACK: begin
                held_speed = SPD_W'(-cs);
                steer = STEER_STRAIGHT;
            end
            CMD_FWD_RIGHT: begin
                held_speed = SPD_W'(cs);
                steer = STEER_R30;
            end
            CMD_FWD_LEFT: begin
                held_speed = SPD_W'(cs);
                steer = STEER_L30;
            end
            CMD_BACK_RIGHT: begin
                held_speed = SPD_W'(-cs);
                steer = STEER_R30;
            end
            CMD_BACK_LEFT: begin
                held_speed = SPD_W'(-cs);
                steer = STEER_L30;
            end
            CMD_BIG_RIGHT: steer = STEER_R45;
            CMD_BIG_LEFT:  steer = STEER_L45;
            default: ;
        endcase

        c = longint'(drive_cfg.servo_center);
        case (steer)
            STEER_R30: begin
                fa = UNITY_Q + DELTA30_Q;
                fb = UNITY_Q - DELTA30_Q;
                sv = c + TURN30;
            end
            STEER_L30: begin
                fa = UNITY_Q - DELTA30_Q;
                fb = UNITY_Q + DELTA30_Q;
                sv = (c > TURN30) ? c - TURN30 - 1 : c - TURN30;
            end
            STEER_R45: begin
                fa = UNITY_Q + DELTA45_Q;
                fb = UNITY_Q - DELTA45_Q;
                sv = c + TURN45;
            end
            STEER_L45: begin
                fa = UNITY_Q - DELTA45_Q;
                fb = UNITY_Q + DELTA45_Q;
                sv = c - TURN45;
            end
            default: begin
                fa = UNITY_Q;
                fb = UNITY_Q;
                sv = c;
            end
        endcase
        if (sv < 0) sv = 0;
        if (sv > SERVO_TOP) sv = SERVO_TOP;

        hs = longint'(held_speed);
        err_l = wheel_target(hs, fa) - longint'($signed(t.enc_left));
        err_r = wheel_target(hs, fb) + longint'($signed(t.enc_right));
        ma = pi_next(longint'(accum_l), longint'(prev_err_l), err_l);
        mb = pi_next(longint'(accum_r), longint'(prev_err_r), err_r);
        accum_l = ACCUM_BITS'(ma);
        accum_r = ACCUM_BITS'(mb);
        prev_err_l = ERR_W'(err_l);
        prev_err_r = ERR_W'(err_r);

        lim = longint'(drive_cfg.drive_limit);
        if (ma > lim) ma = lim;
        if (ma < -lim) ma = -lim;
        if (mb > lim) mb = lim;
        if (mb < -lim) mb = -lim;

        pair = bridge_split(ma);
        r.pwm_a_forward = pair[2*PWM_W-1:PWM_W];
        r.pwm_a_reverse = pair[PWM_W-1:0];
        pair = bridge_split(mb);
        r.pwm_b_forward = pair[2*PWM_W-1:PWM_W];
        r.pwm_b_reverse = pair[PWM_W-1:0];
        r.servo_pulse = SERVO_W'(sv);
        return r;
    endfunction

    task automatic offer_tick(t_item t, logic typed, t_result want);
        t_result guess;
        tick_if.valid               <= 1'b1;
        tick_if.command             <= t.command;
        tick_if.obstacle_left       <= t.obstacle[2];
        tick_if.obstacle_center     <= t.obstacle[1];
        tick_if.obstacle_right      <= t.obstacle[0];
        tick_if.encoder_left_count  <= t.enc_left;
        tick_if.encoder_right_count <= t.enc_right;
        do @(posedge i_clk); while (!tick_if.ready);
        guess = drive_step(t);
        pending_drive.push_back(typed ? want : guess);
        ticks_sent++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            tick_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        tick_if.valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_OBSTACLE_MODE: drive_cfg.obstacle_mode = value[0];
            CFG_CRUISE_SPEED:  drive_cfg.cruise_speed  = value[MAG_W-1:0];
            CFG_GAIN_P:        drive_cfg.gain_p        = value[GAIN_W-1:0];
            CFG_GAIN_I:        drive_cfg.gain_i        = value[GAIN_W-1:0];
            CFG_SERVO_CENTER:  drive_cfg.servo_center  = value[SERVO_W-1:0];
            CFG_DRIVE_LIMIT:   drive_cfg.drive_limit   = value[LIMIT_W-1:0];
            CFG_PWM_PERIOD:    drive_cfg.pwm_period    = value[PWM_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_cfg(t_cfg c);
        write_reg(CFG_OBSTACLE_MODE, CFG_DATA_W'(c.obstacle_mode));
        write_reg(CFG_CRUISE_SPEED,  CFG_DATA_W'(c.cruise_speed));
        write_reg(CFG_GAIN_P,        CFG_DATA_W'(c.gain_p));
        write_reg(CFG_GAIN_I,        CFG_DATA_W'(c.gain_i));
        write_reg(CFG_SERVO_CENTER,  CFG_DATA_W'(c.servo_center));
        write_reg(CFG_DRIVE_LIMIT,   CFG_DATA_W'(c.drive_limit));
        write_reg(CFG_PWM_PERIOD,    CFG_DATA_W'(c.pwm_period));
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && drive_if.valid && drive_if.ready) begin
            results_seen++;
            if (pending_drive.size() == 0) begin
                $error("result beat with no tick pending");
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                check_field("pwm_a_forward", want.pwm_a_forward, drive_if.pwm_a_forward);
                check_field("pwm_a_reverse", want.pwm_a_reverse, drive_if.pwm_a_reverse);
                check_field("pwm_b_forward", want.pwm_b_forward, drive_if.pwm_b_forward);
                check_field("pwm_b_reverse", want.pwm_b_reverse, drive_if.pwm_b_reverse);
                check_field("servo_pulse", want.servo_pulse, drive_if.servo_pulse);
            end
        end
    end

    initial begin
        int hold_left;
        int holds_done;
        int stall_phase;
        hold_left = 0;
        holds_done = 0;
        stall_phase = 0;
        drive_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                drive_if.ready <= 1'b0;
            end else if (holds_done != hold_reqs) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
                drive_if.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    SINK_RANDOM: drive_if.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE: drive_if.ready <= ($urandom_range(0, 3) == 0);
                    SINK_CYCLE: begin
                        stall_phase = (stall_phase + 1) % 7;
                        drive_if.ready <= (stall_phase < 4);
                    end
                    default: drive_if.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_cfg       nc;
        t_item      tk;
        t_sink_mode sm;
        t_feed_mode feed;
        t_pressure  press;
        int         gap_max;
        int         burst_left;
        int         base;

        i_rst_n = 1'b0;
        tick_if.valid = 1'b0;
        tick_if.command = '0;
        tick_if.obstacle_left = 1'b0;
        tick_if.obstacle_center = 1'b0;
        tick_if.obstacle_right = 1'b0;
        tick_if.encoder_left_count = '0;
        tick_if.encoder_right_count = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_OBSTACLE_MODE;
        cfg_if.data = '0;

        drive_cfg = '{1'b0, '0, '0, '0, CENTER_RST, LIMIT_RST, PERIOD_RST};
        held_speed = '0;
        steer = STEER_STRAIGHT;
        accum_l = '0;
        accum_r = '0;
        prev_err_l = '0;
        prev_err_r = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_SPLIT; k++)
            offer_tick(dir_rows[k].tick, dir_rows[k].typed, dir_rows[k].want);
        drain_results();
        apply_cfg(SET_FULL_TILT);
        for (int k = DIR_SPLIT; k < DIR_ROWS; k++)
            offer_tick(dir_rows[k].tick, dir_rows[k].typed, dir_rows[k].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            nc = SET_FULL_TILT;
            nc.obstacle_mode = 1'b0;
            press = PRESS_NONE;
            case (ph)
                0: begin
                    nc = '{1'b0, 11'd300, 10'd20, 10'd5, 12'd1500, 13'd6900, 16'd7200};
                    sm = SINK_CYCLE;
                    gap_max = 3;
                    feed = FEED_TRACK;
                    press = PRESS_HOLD;
                end
                1: begin
                    nc = SET_FULL_TILT;
                    sm = SINK_OPEN;
                    gap_max = 0;
                    feed = FEED_PINNED;
                end
                2: begin
                    nc = '{1'b0, 11'd0, 10'd0, 10'd1, 12'd500, 13'd0, 16'd1};
                    sm = SINK_RANDOM;
                    gap_max = 8;
                    feed = FEED_NOISE;
                end
                3: begin
                    nc.cruise_speed = MAG_W'($urandom_range(0, 2047));
                    nc.gain_p = GAIN_W'($urandom_range(0, 1023));
                    nc.gain_i = GAIN_W'($urandom_range(0, 1023));
                    nc.servo_center = '0;
                    nc.drive_limit = 13'd8191;
                    nc.pwm_period = 16'd100;
                    sm = SINK_SPARSE;
                    gap_max = 2;
                    feed = FEED_TRACK;
                    press = PRESS_DRAIN;
                end
                4: begin
                    nc.obstacle_mode = 1'b1;
                    nc.cruise_speed = MAG_W'($urandom_range(0, 2047));
                    nc.gain_p = GAIN_W'($urandom_range(0, 1023));
                    nc.gain_i = GAIN_W'($urandom_range(0, 1023));
                    nc.servo_center = 12'd4095;
                    nc.drive_limit = LIMIT_W'($urandom_range(0, 7200));
                    nc.pwm_period = 16'hFFFF;
                    sm = SINK_RANDOM;
                    gap_max = 15;
                    feed = FEED_NOISE;
                end
                5: begin
                    nc.obstacle_mode = 1'($urandom_range(0, 1));
                    nc.cruise_speed = MAG_W'($urandom_range(0, 2047));
                    nc.gain_p = GAIN_W'($urandom_range(0, 1023));
                    nc.gain_i = GAIN_W'($urandom_range(0, 1023));
                    nc.servo_center = SERVO_W'($urandom_range(0, 4095));
                    nc.drive_limit = LIMIT_W'($urandom_range(0, 8191));
                    nc.pwm_period = PWM_W'($urandom_range(1, 65535));
                    sm = SINK_CYCLE;
                    gap_max = 3;
                    feed = FEED_TRACK;
                end
                6: begin
                    nc = '{1'b0, 11'd1024, 10'd1, 10'd0, 12'd419, 13'd7200, 16'd7200};
                    sm = SINK_OPEN;
                    gap_max = 6;
                    feed = FEED_PINNED;
                end
                default: begin
                    nc = '{1'b0, 11'd2047, 10'd1023, 10'd1023, 12'd420, 13'd6900, 16'd7200};
                    sm = SINK_RANDOM;
                    gap_max = 0;
                    feed = FEED_TRACK;
                    press = PRESS_HOLD;
                end
            endcase
            apply_cfg(nc);
            sink_mode <= sm;
            burst_left = 0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k == PRESSURE_AT && press == PRESS_HOLD) hold_reqs <= hold_reqs + 1;
                if (k == PRESSURE_AT && press == PRESS_DRAIN) drain_results();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    idle_gap($urandom_range(0, gap_max));
                end
                burst_left--;

                if ($urandom_range(0, 9) < 8) tk.command = CMD_W'($urandom_range(0, 8));
                else tk.command = CMD_W'($urandom_range(9, 15));
                tk.obstacle = 3'($urandom_range(0, 7));
                case (feed)
                    FEED_TRACK: begin
                        base = int'(held_speed) + int'($urandom_range(0, 80)) - 40;
                        tk.enc_left = ENC_W'(base);
                        tk.enc_right = ENC_W'(-(base + int'($urandom_range(0, 16)) - 8));
                    end
                    FEED_PINNED: begin
                        tk.enc_left = (k < PIN_FLIP) ? 16'sh8000 : 16'sh7FFF;
                        tk.enc_right = (k < PIN_FLIP) ? 16'sh7FFF : 16'sh8000;
                    end
                    default: begin
                        tk.enc_left = ENC_W'($urandom_range(0, 65535));
                        tk.enc_right = ENC_W'($urandom_range(0, 65535));
                    end
                endcase
                offer_tick(tk, 1'b0, NO_WANT);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d ticks (%0d directed) under %0d settings, %0d register writes.",
                 ticks_sent, DIR_ROWS, PHASES + 2, reg_writes);
        $display("Checked %0d results in %0d cycles, %0d mismatches.",
                 results_seen, cycle_cnt, mismatches);
        if (mismatches == 0 && pending_drive.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/scpd_pkg.sv
rtl/scpd_if.sv
rtl/scpd_cfg_regs.sv
rtl/scpd_mul.sv
rtl/scpd_core.sv
rtl/steered_car_dual_pi_drive.sv
tb/sv/testbench.sv
